@@ hdl/gradient_vector_compressor_core_assert.svh @@
// Assertion macros for the gradient vector compressor checker
`ifndef GRADIENT_VECTOR_COMPRESSOR_CORE_ASSERT_SVH
`define GRADIENT_VECTOR_COMPRESSOR_CORE_ASSERT_SVH
// same-cycle implication
`define GVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gvc check failed");
// next-cycle implication
`define GVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gvc check failed");
`endif

@@ hdl/gvc_pkg.sv @@
// Shared types, constants and helpers for the gradient vector compressor
`default_nettype none
package gvc_pkg;
    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_TOPK   = 3'd1,
        MODE_THRESH = 3'd2,
        MODE_QUANT  = 3'd3,
        MODE_DELTA  = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        BK_IDLE, BK_MAXRD, BK_MAXUSE, BK_ELRD, BK_ELUSE,
        BK_KRD, BK_KUSE, BK_DIV, BK_SIGN, BK_OUT
    } t_bk_state;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_RATIO = 1'b1;

    localparam logic [31:0] THRESH_RAW = 32'd1678;
    localparam logic [6:0]  QUANT_SCALE = 7'd127;
    localparam logic [16:0] RATIO_ONE = 17'd65536;
    localparam int          DIV_STEPS = 32;

    function automatic logic [31:0] mag(input logic [31:0] v);
        mag = v[31] ? (32'd0 - v) : v;
    endfunction
endpackage
`default_nettype wire

@@ hdl/gvc_job_fifo.sv @@
// Two-entry queue carrying vector run lengths from loader to engine
`default_nettype none
module gvc_job_fifo #(
    parameter int W = 7
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
endmodule
`default_nettype wire

@@ hdl/gvc_front.sv @@
// Input loader: counts elements, writes the store, queues a run on the last one
`default_nettype none
module gvc_front #(
    parameter int MAX_ELEMENTS = 64,
    parameter int CW = 7,
    parameter int AW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,
    input  wire logic          s_axis_tlast,
    input  wire logic          i_run_done,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [31:0]        o_wr_data,
    output logic               o_job_push,
    output logic [CW-1:0]      o_job_count
);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          acc, room;

    assign s_axis_tready = !r_busy;
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign room = (r_cnt < MAX_C);

    assign o_wr_en     = acc && room;
    assign o_wr_addr   = r_cnt[AW-1:0];
    assign o_wr_data   = s_axis_tdata;
    assign o_job_push  = acc && s_axis_tlast;
    assign o_job_count = room ? (r_cnt + CW'(1)) : r_cnt;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (acc) begin
            if (s_axis_tlast) begin
                n_cnt  = '0;
                n_busy = 1'b1;
            end else if (room) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
        if (i_run_done) n_busy = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
    end
endmodule
`default_nettype wire

@@ hdl/gvc_back.sv @@
// Compression engine: walks the stored vector and emits one result per element
`default_nettype none
module gvc_back #(
    parameter int MAX_ELEMENTS = 64,
    parameter int CW = 7,
    parameter int AW = 6
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr_en,
    input  wire logic [AW-1:0]  i_wr_addr,
    input  wire logic [31:0]    i_wr_data,
    input  wire logic           i_job_valid,
    input  wire logic [CW-1:0]  i_job_count,
    output logic                o_job_pop,
    input  wire gvc_pkg::t_mode i_mode,
    input  wire logic [16:0]    i_ratio,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [31:0]         m_axis_tdata,
    output logic                m_axis_tlast,
    output logic                m_axis_tuser,
    output logic                o_run_done
);
    import gvc_pkg::*;

    logic [31:0] r_store [MAX_ELEMENTS];
    logic [31:0] r_prevv [MAX_ELEMENTS];
    logic [31:0] r_rd, r_prd;

    t_bk_state r_state, n_state;
    t_mode     r_mode, n_mode, mode_eff;
    logic [CW-1:0] r_n, n_n, r_k, n_k, r_j, n_j, r_ahead, n_ahead, r_pcnt, n_pcnt;
    logic [AW-1:0] r_i, n_i;
    logic [31:0]   r_max, n_max, r_val, n_val, r_res, n_res, r_lo, n_lo;
    logic [32:0]   r_rem, n_rem;
    logic [5:0]    r_dc, n_dc;
    logic          r_z, n_z, r_pvalid, n_pvalid;

    logic [AW-1:0]    rd_addr;
    logic             prev_we, last_el, last_j;
    logic [16:0]      ratio_c;
    logic [CW+16:0]   kprod;
    logic [31:0]      m_rd, m_val, max_new;
    logic [38:0]      qprod;
    logic [63:0]      dvd;
    logic [33:0]      trial;
    logic [32:0]      dv, diff;
    logic [CW-1:0]    ahead_new;

    assign mode_eff = (i_mode > MODE_DELTA) ? MODE_NONE : i_mode;
    assign rd_addr  = (r_state == BK_ELRD) ? r_i : r_j[AW-1:0];
    assign last_el  = ({{(CW-AW){1'b0}}, r_i} == r_n - CW'(1));
    assign last_j   = (r_j == r_n - CW'(1));
    assign ratio_c  = (i_ratio > RATIO_ONE) ? RATIO_ONE : i_ratio;
    assign kprod    = i_job_count * ratio_c;
    assign m_rd     = mag(r_rd);
    assign m_val    = mag(r_val);
    assign max_new  = (m_rd > r_max) ? m_rd : r_max;
    assign qprod    = m_rd * QUANT_SCALE;
    assign dvd      = {qprod[38:0], 25'd0} + {32'd0, r_max};
    assign dv       = {r_max, 1'b0};
    assign trial    = {r_rem, r_lo[31]};
    assign diff     = {r_rd[31], r_rd} - {r_prd[31], r_prd};
    assign ahead_new = ((m_rd > m_val) ||
                        ((m_rd == m_val) && (r_j < {{(CW-AW){1'b0}}, r_i})))
                       ? (r_ahead + CW'(1)) : r_ahead;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_store[i_wr_addr] <= i_wr_data;
        r_rd  <= r_store[rd_addr];
        r_prd <= r_prevv[r_i];
        if (prev_we) r_prevv[r_i] <= r_rd;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:   if (i_job_valid) begin
                n_state = (mode_eff == MODE_QUANT) ? BK_MAXRD : BK_ELRD;
            end
            BK_MAXRD:  n_state = BK_MAXUSE;
            BK_MAXUSE: n_state = last_j ? BK_ELRD : BK_MAXRD;
            BK_ELRD:   n_state = BK_ELUSE;
            BK_ELUSE: begin
                if (r_mode == MODE_TOPK) n_state = BK_KRD;
                else if (r_mode == MODE_QUANT && !r_z) n_state = BK_DIV;
                else n_state = BK_OUT;
            end
            BK_KRD:    n_state = BK_KUSE;
            BK_KUSE:   n_state = last_j ? BK_OUT : BK_KRD;
            BK_DIV:    n_state = (r_dc == 6'(DIV_STEPS - 1)) ? BK_SIGN : BK_DIV;
            BK_SIGN:   n_state = BK_OUT;
            BK_OUT:    if (m_axis_tready) begin
                n_state = last_el ? BK_IDLE : BK_ELRD;
            end
            default:   n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop     = (r_state == BK_IDLE) && i_job_valid;
        m_axis_tvalid = (r_state == BK_OUT);
        o_run_done    = (r_state == BK_OUT) && m_axis_tready && last_el;
        prev_we       = (r_state == BK_ELUSE) && (r_mode == MODE_DELTA);
    end

    assign m_axis_tdata = r_res;
    assign m_axis_tlast = last_el;
    assign m_axis_tuser = r_z;

    always_comb begin
        n_mode = r_mode; n_n = r_n; n_k = r_k; n_j = r_j; n_i = r_i;
        n_ahead = r_ahead; n_max = r_max; n_val = r_val; n_res = r_res;
        n_lo = r_lo; n_rem = r_rem; n_dc = r_dc; n_z = r_z;
        n_pcnt = r_pcnt; n_pvalid = r_pvalid;
        case (r_state)
            BK_IDLE: if (i_job_valid) begin
                n_mode = mode_eff;
                n_n    = i_job_count;
                n_k    = kprod[CW+15:16];
                n_j    = '0;
                n_i    = '0;
                n_max  = '0;
                n_z    = 1'b0;
            end
            BK_MAXUSE: begin
                n_max = max_new;
                n_j   = r_j + CW'(1);
                if (last_j) n_z = (max_new == 32'd0);
            end
            BK_ELUSE: begin
                n_val = r_rd;
                case (r_mode)
                    MODE_TOPK: begin
                        n_j     = '0;
                        n_ahead = '0;
                    end
                    MODE_THRESH: n_res = (m_rd < THRESH_RAW) ? 32'd0 : r_rd;
                    MODE_QUANT: begin
                        n_res = 32'd0;
                        n_rem = dvd[63:32];
                        n_lo  = dvd[31:0];
                        n_dc  = '0;
                    end
                    MODE_DELTA: begin
                        if (r_pvalid && ({{(CW-AW){1'b0}}, r_i} < r_pcnt)) begin
                            if (diff[32] != diff[31])
                                n_res = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                            else
                                n_res = diff[31:0];
                        end else begin
                            n_res = r_rd;
                        end
                    end
                    default: n_res = r_rd;
                endcase
            end
            BK_KUSE: begin
                n_ahead = ahead_new;
                n_j     = r_j + CW'(1);
                if (last_j) n_res = (ahead_new < r_k) ? r_val : 32'd0;
            end
            BK_DIV: begin
                if (trial >= {1'b0, dv}) begin
                    n_rem = 33'(trial - {1'b0, dv});
                    n_lo  = {r_lo[30:0], 1'b1};
                end else begin
                    n_rem = trial[32:0];
                    n_lo  = {r_lo[30:0], 1'b0};
                end
                n_dc = r_dc + 6'd1;
            end
            BK_SIGN: n_res = r_val[31] ? (32'd0 - r_lo) : r_lo;
            BK_OUT: if (m_axis_tready) begin
                n_i = r_i + AW'(1);
                if (last_el && r_mode == MODE_DELTA) begin
                    n_pcnt   = r_n;
                    n_pvalid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_pvalid <= 1'b0;
            r_pcnt   <= '0;
            r_z      <= 1'b0;
            r_i      <= '0;
            r_n      <= '0;
        end else begin
            r_state  <= n_state;
            r_pvalid <= n_pvalid;
            r_pcnt   <= n_pcnt;
            r_z      <= n_z;
            r_i      <= n_i;
            r_n      <= n_n;
        end
        r_mode  <= n_mode;
        r_k     <= n_k;
        r_j     <= n_j;
        r_ahead <= n_ahead;
        r_max   <= n_max;
        r_val   <= n_val;
        r_res   <= n_res;
        r_lo    <= n_lo;
        r_rem   <= n_rem;
        r_dc    <= n_dc;
    end
endmodule
`default_nettype wire

@@ hdl/gradient_vector_compressor_core.sv @@
// Gradient vector compressor top level: configuration registers, loader, queue, engine
// Elements load at one per cycle, while s_axis_tready is high, into a vector store; the
// transaction marked tlast starts a run that emits every element in index order, and
// no input is taken until the run's last result is delivered. Per element the engine
// reads the element, processes it and then offers the result for the output handshake
// in pass-through, threshold and delta modes; top-k adds a full magnitude scan of the
// store through its single read port; quantize adds a maximum search per run and a
// bit-serial divide per element (32 steps and a sign fix). While the output is held
// off, the engine waits.
`default_nettype none
module gradient_vector_compressor_core #(
    parameter int MAX_ELEMENTS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] grad_value
    input  wire logic        s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] out_value
    output logic             m_axis_tlast,   // out_last
    output logic             m_axis_tuser,   // [0] zero_scale
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [16:0] i_cfg_data
);
    import gvc_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS) + 1;
    localparam int AW = $clog2(MAX_ELEMENTS);

    t_mode         r_mode;
    logic [16:0]   r_ratio;
    logic          wr_en, job_push, job_valid, job_pop, run_done;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [CW-1:0] job_count_in, job_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NONE;
            r_ratio <= RATIO_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[2:0]);
                CFG_RATIO: r_ratio <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    gvc_front #(.MAX_ELEMENTS(MAX_ELEMENTS), .CW(CW), .AW(AW)) u_front (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .i_run_done  (run_done),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_job_push  (job_push),
        .o_job_count (job_count_in)
    );

    gvc_job_fifo #(.W(CW)) u_fifo (
        .i_clk, .i_rst_n,
        .i_push  (job_push),
        .i_data  (job_count_in),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_data  (job_count)
    );

    gvc_back #(.MAX_ELEMENTS(MAX_ELEMENTS), .CW(CW), .AW(AW)) u_back (
        .i_clk, .i_rst_n,
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_job_valid (job_valid),
        .i_job_count (job_count),
        .o_job_pop   (job_pop),
        .i_mode      (r_mode),
        .i_ratio     (r_ratio),
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
        .o_run_done  (run_done)
    );
endmodule
`default_nettype wire

@@ hdl/gvc_checker.sv @@
// Port-level checker for the gradient vector compressor, bound to the top level
`default_nettype none
`include "gradient_vector_compressor_core_assert.svh"
module gvc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);
    `GVC_ASSERT_IMP(a_no_load_during_run, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `GVC_ASSERT_NXT(a_last_blocks_input, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
    `GVC_ASSERT_IMP(a_idle_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !m_axis_tvalid)
    `GVC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind gradient_vector_compressor_core gvc_checker u_gvc_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
